// ===== rtl/core/tsg_pkg.sv =====
package tsg_pkg;

  // Configuration register widths and port format
  localparam int unsigned CFG_DIST_W = 12;
  localparam int unsigned CFG_TIME_W = 16;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SWIPE_MIN_DIST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SWIPE_MAX_DUR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SUPPRESS_DIST  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_CONFIRM    = 2'd3;

  // Reset values
  localparam logic [CFG_DIST_W-1:0] RST_SWIPE_MIN_DIST = 12'd80;
  localparam logic [CFG_TIME_W-1:0] RST_SWIPE_MAX_DUR  = 16'd600;
  localparam logic [CFG_DIST_W-1:0] RST_SUPPRESS_DIST  = 12'd30;
  localparam logic [CFG_TIME_W-1:0] RST_TAP_CONFIRM    = 16'd120;

  // Gesture codes
  localparam int unsigned GEST_W = 3;
  localparam logic [GEST_W-1:0] GEST_NONE  = 3'd0;
  localparam logic [GEST_W-1:0] GEST_RIGHT = 3'd1;
  localparam logic [GEST_W-1:0] GEST_LEFT  = 3'd2;
  localparam logic [GEST_W-1:0] GEST_DOWN  = 3'd3;
  localparam logic [GEST_W-1:0] GEST_UP    = 3'd4;

  typedef struct packed {
    logic [CFG_DIST_W-1:0] swipe_min_dist;
    logic [CFG_TIME_W-1:0] swipe_max_dur;
    logic [CFG_DIST_W-1:0] suppress_dist;
    logic [CFG_TIME_W-1:0] tap_confirm;
  } cfg_t;

endpackage

// ===== rtl/core/tsg_if.sv =====
interface tsg_sample_if #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned TIME_BITS  = 32
);
  logic                  valid;
  logic                  ready;
  logic                  pen_down;
  logic [COORD_BITS-1:0] sample_x;
  logic [COORD_BITS-1:0] sample_y;
  logic [TIME_BITS-1:0]  time_ms;

  modport source (output valid, pen_down, sample_x, sample_y, time_ms, input ready);
  modport sink   (input valid, pen_down, sample_x, sample_y, time_ms, output ready);
endinterface

interface tsg_result_if #(
  parameter int unsigned COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic [2:0]            gesture;
  logic                  press_reported;
  logic [COORD_BITS-1:0] report_x;
  logic [COORD_BITS-1:0] report_y;

  modport source (output valid, gesture, press_reported, report_x, report_y, input ready);
  modport sink   (input valid, gesture, press_reported, report_x, report_y, output ready);
endinterface

// ===== rtl/core/tsg_cfg_regs.sv =====
module tsg_cfg_regs
  import tsg_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.swipe_min_dist <= RST_SWIPE_MIN_DIST;
      cfg_q.swipe_max_dur  <= RST_SWIPE_MAX_DUR;
      cfg_q.suppress_dist  <= RST_SUPPRESS_DIST;
      cfg_q.tap_confirm    <= RST_TAP_CONFIRM;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SWIPE_MIN_DIST: cfg_q.swipe_min_dist <= cfg_data_i[CFG_DIST_W-1:0];
        CFG_SWIPE_MAX_DUR:  cfg_q.swipe_max_dur  <= cfg_data_i[CFG_TIME_W-1:0];
        CFG_SUPPRESS_DIST:  cfg_q.suppress_dist  <= cfg_data_i[CFG_DIST_W-1:0];
        CFG_TAP_CONFIRM:    cfg_q.tap_confirm    <= cfg_data_i[CFG_TIME_W-1:0];
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/tsg_classify.sv =====
module tsg_classify
  import tsg_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic [COORD_BITS-1:0] cur_x_i,
  input  logic [COORD_BITS-1:0] cur_y_i,
  input  logic [COORD_BITS-1:0] start_x_i,
  input  logic [COORD_BITS-1:0] start_y_i,
  input  logic [CFG_DIST_W-1:0] min_dist_i,
  output logic [GEST_W-1:0]     gesture_o
);

  localparam int unsigned CW = (COORD_BITS > CFG_DIST_W) ? COORD_BITS : CFG_DIST_W;
  localparam int unsigned PW = COORD_BITS + 2;

  logic [COORD_BITS-1:0] ax, ay;
  logic [PW-1:0]         ax2, ay2, ax3, ay3;
  logic                  x_ok, y_ok;

  always_comb begin
    ax  = (cur_x_i >= start_x_i) ? (cur_x_i - start_x_i) : (start_x_i - cur_x_i);
    ay  = (cur_y_i >= start_y_i) ? (cur_y_i - start_y_i) : (start_y_i - cur_y_i);
    // 1.5 ratio as 2a > 3b, no rounding
    ax2 = {1'b0, ax, 1'b0};
    ay2 = {1'b0, ay, 1'b0};
    ax3 = ax2 + PW'(ax);
    ay3 = ay2 + PW'(ay);
    x_ok = (ax > ay) && (CW'(ax) >= CW'(min_dist_i)) && (ax2 > ay3);
    y_ok = (ay > ax) && (CW'(ay) >= CW'(min_dist_i)) && (ay2 > ax3);
    priority if (x_ok) begin
      gesture_o = (cur_x_i > start_x_i) ? GEST_RIGHT : GEST_LEFT;
    end else if (y_ok) begin
      gesture_o = (cur_y_i > start_y_i) ? GEST_DOWN : GEST_UP;
    end else begin
      gesture_o = GEST_NONE;
    end
  end

endmodule

// ===== rtl/core/touch_swipe_gesture_detector.sv =====
// Channel   Dir  Payload                                         Accepted when
// sample_i  in   pen_down, sample_x, sample_y, time_ms           valid && ready
// result_o  out  gesture, press_reported, report_x, report_y     valid && ready
// cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i                 cfg_we_i high
//
// One item per clock sustained while result_o is not stalled. An accepted item is loaded
// into the input register, then the tracker update moves into the result register
// once that register is free or empties.
// The tracker state is read and written once per item in the second stage.
// rst_ni clears the tracker state, both valid flags and loads the register defaults.
// A stalled result holds the pipeline; the input stage still takes an item
// while it is empty.
module touch_swipe_gesture_detector
  import tsg_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned TIME_BITS  = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  tsg_sample_if.sink            sample_i,
  tsg_result_if.source          result_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t cfg;

  tsg_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .cfg_o     (cfg)
  );

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic                  in_valid_q;
  logic                  in_pen_q;
  logic [COORD_BITS-1:0] in_x_q, in_y_q;
  logic [TIME_BITS-1:0]  in_time_q;

  logic out_valid_q;
  logic advance;

  // Result register is free, or empties this cycle
  assign advance        = !out_valid_q || result_o.ready;
  assign sample_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (sample_i.ready) begin
      in_valid_q <= sample_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_i.ready && sample_i.valid) begin
      in_pen_q  <= sample_i.pen_down;
      in_x_q    <= sample_i.sample_x;
      in_y_q    <= sample_i.sample_y;
      in_time_q <= sample_i.time_ms;
    end
  end

  // ---------------------------------------------------------------------------
  // Tracker state
  // ---------------------------------------------------------------------------
  localparam int unsigned CW = (COORD_BITS > CFG_DIST_W) ? COORD_BITS : CFG_DIST_W;

  logic                  tracking_q, tracking_d;
  logic                  swipe_q, swipe_d;
  logic                  was_down_q;
  logic [COORD_BITS-1:0] start_x_q, start_x_d, start_y_q, start_y_d;
  logic [TIME_BITS-1:0]  start_time_q, start_time_d;
  logic [COORD_BITS-1:0] last_x_q, last_x_d, last_y_q, last_y_d;

  logic                  press, release_ev, trk1, sw1, sw2, move_hit;
  logic [COORD_BITS-1:0] dx, dy;
  logic [TIME_BITS-1:0]  dt;
  logic [GEST_W-1:0]     class_code, gesture_d;
  logic                  pressed_d;

  tsg_classify #(
    .COORD_BITS(COORD_BITS)
  ) u_classify (
    .cur_x_i   (last_x_d),
    .cur_y_i   (last_y_d),
    .start_x_i (start_x_d),
    .start_y_i (start_y_d),
    .min_dist_i(cfg.swipe_min_dist),
    .gesture_o (class_code)
  );

  always_comb begin
    // Latch coordinates only while the pen is down
    last_x_d = in_pen_q ? in_x_q : last_x_q;
    last_y_d = in_pen_q ? in_y_q : last_y_q;

    // Press: restart tracking from this sample
    press        = in_pen_q && !was_down_q;
    trk1         = press ? 1'b1 : tracking_q;
    sw1          = press ? 1'b0 : swipe_q;
    start_x_d    = press ? last_x_d : start_x_q;
    start_y_d    = press ? last_y_d : start_y_q;
    start_time_d = press ? in_time_q : start_time_q;

    // Travel from the start point marks a swipe
    dx = (last_x_d >= start_x_d) ? (last_x_d - start_x_d) : (start_x_d - last_x_d);
    dy = (last_y_d >= start_y_d) ? (last_y_d - start_y_d) : (start_y_d - last_y_d);
    move_hit = (CW'(dx) >= CW'(cfg.suppress_dist)) || (CW'(dy) >= CW'(cfg.suppress_dist));
    sw2 = (in_pen_q && trk1 && !sw1 && move_hit) ? 1'b1 : sw1;

    // Press duration wraps with the timestamp
    dt = in_time_q - start_time_d;

    // Release: classify a qualifying swipe, then drop tracking
    release_ev = !in_pen_q && was_down_q && trk1;
    gesture_d  = GEST_NONE;
    if (release_ev && sw2 && (dt <= TIME_BITS'(cfg.swipe_max_dur))) begin
      gesture_d = class_code;
    end
    tracking_d = release_ev ? 1'b0 : trk1;
    swipe_d    = release_ev ? 1'b0 : sw2;

    // Pointer view: hold off during a swipe and the tap-confirm window
    priority if (swipe_d) begin
      pressed_d = 1'b0;
    end else if (in_pen_q && tracking_d && (dt < TIME_BITS'(cfg.tap_confirm))) begin
      pressed_d = 1'b0;
    end else begin
      pressed_d = in_pen_q;
    end
  end

  logic step;
  assign step = in_valid_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tracking_q   <= 1'b0;
      swipe_q      <= 1'b0;
      was_down_q   <= 1'b0;
      start_x_q    <= '0;
      start_y_q    <= '0;
      start_time_q <= '0;
      last_x_q     <= '0;
      last_y_q     <= '0;
    end else if (step) begin
      tracking_q   <= tracking_d;
      swipe_q      <= swipe_d;
      was_down_q   <= in_pen_q;
      start_x_q    <= start_x_d;
      start_y_q    <= start_y_d;
      start_time_q <= start_time_d;
      last_x_q     <= last_x_d;
      last_y_q     <= last_y_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic [GEST_W-1:0]     out_gesture_q;
  logic                  out_pressed_q;
  logic [COORD_BITS-1:0] out_x_q, out_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_gesture_q <= gesture_d;
      out_pressed_q <= pressed_d;
      out_x_q       <= last_x_d;
      out_y_q       <= last_y_d;
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.gesture        = out_gesture_q;
  assign result_o.press_reported = out_pressed_q;
  assign result_o.report_x       = out_x_q;
  assign result_o.report_y       = out_y_q;

endmodule

// ===== verif/touch_swipe_gesture_detector_checker.sv =====
`timescale 1ns / 1ps

module touch_swipe_gesture_detector_checker
  import tsg_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned TIME_BITS  = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  tsg_sample_if                 sample_i,
  tsg_result_if                 result_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned           mismatches_o,
  output int unsigned           pending_o,
  output int unsigned           results_o,
  output int unsigned           swipes_o
);

  localparam int unsigned REPORT_LIMIT = 10;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [TIME_BITS-1:0]  stamp_t;

  typedef struct packed {
    logic [GEST_W-1:0] gesture;
    logic              pressed;
    coord_t            x;
    coord_t            y;
  } touch_report_t;

  // Threshold mirror
  logic [CFG_DIST_W-1:0] min_travel;
  logic [CFG_TIME_W-1:0] max_swipe_ms;
  logic [CFG_DIST_W-1:0] swipe_travel;
  logic [CFG_TIME_W-1:0] tap_hold_ms;

  // Tracker mirror
  logic   pen_was_down;
  logic   tracking;
  logic   swiping;
  coord_t origin_x;
  coord_t origin_y;
  coord_t latched_x;
  coord_t latched_y;
  stamp_t press_stamp;

  touch_report_t expected_q[$];
  int unsigned   mismatch_count;
  int unsigned   result_count;
  int unsigned   swipe_count;

  function automatic coord_t travel(coord_t a, coord_t b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // Advance the tracker mirror by one poll and return the report it yields.
  function automatic touch_report_t predict_report(logic pen, coord_t x, coord_t y,
                                                   stamp_t stamp);
    touch_report_t rep;
    coord_t        dx;
    coord_t        dy;
    stamp_t        held;
    rep.gesture = GEST_NONE;
    if (pen) begin
      latched_x = x;
      latched_y = y;
    end
    if (pen && !pen_was_down) begin
      tracking    = 1'b1;
      swiping     = 1'b0;
      origin_x    = latched_x;
      origin_y    = latched_y;
      press_stamp = stamp;
    end
    dx   = travel(latched_x, origin_x);
    dy   = travel(latched_y, origin_y);
    held = stamp - press_stamp;
    if (pen && tracking && !swiping && (dx >= swipe_travel || dy >= swipe_travel))
      swiping = 1'b1;
    if (!pen && pen_was_down && tracking) begin
      tracking = 1'b0;
      if (swiping && held <= stamp_t'(max_swipe_ms)) begin
        if (dx > dy && dx >= min_travel && 2 * int'(dx) > 3 * int'(dy))
          rep.gesture = (latched_x > origin_x) ? GEST_RIGHT : GEST_LEFT;
        else if (dy > dx && dy >= min_travel && 2 * int'(dy) > 3 * int'(dx))
          rep.gesture = (latched_y > origin_y) ? GEST_DOWN : GEST_UP;
      end
      swiping = 1'b0;
    end
    pen_was_down = pen;
    rep.pressed  = pen;
    if (swiping || (pen && tracking && held < stamp_t'(tap_hold_ms)))
      rep.pressed = 1'b0;
    rep.x = latched_x;
    rep.y = latched_y;
    return rep;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    touch_report_t want;
    if (!rst_ni) begin
      min_travel     = RST_SWIPE_MIN_DIST;
      max_swipe_ms   = RST_SWIPE_MAX_DUR;
      swipe_travel   = RST_SUPPRESS_DIST;
      tap_hold_ms    = RST_TAP_CONFIRM;
      pen_was_down   = 1'b0;
      tracking       = 1'b0;
      swiping        = 1'b0;
      origin_x       = '0;
      origin_y       = '0;
      latched_x      = '0;
      latched_y      = '0;
      press_stamp    = '0;
      expected_q.delete();
      mismatch_count = 0;
      result_count   = 0;
      swipe_count    = 0;
      mismatches_o  <= 0;
      pending_o     <= 0;
      results_o     <= 0;
      swipes_o      <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SWIPE_MIN_DIST: min_travel   = cfg_data_i[CFG_DIST_W-1:0];
          CFG_SWIPE_MAX_DUR:  max_swipe_ms = cfg_data_i[CFG_TIME_W-1:0];
          CFG_SUPPRESS_DIST:  swipe_travel = cfg_data_i[CFG_DIST_W-1:0];
          CFG_TAP_CONFIRM:    tap_hold_ms  = cfg_data_i[CFG_TIME_W-1:0];
          default: ;
        endcase
      end
      // Compare before pushing: a result can never answer a same-edge sample.
      if (result_i.valid && result_i.ready) begin
        result_count++;
        if (expected_q.size() == 0) begin
          if (mismatch_count < REPORT_LIMIT)
            $display("%0t: result with nothing expected: gesture %0d press %0b x %0d y %0d",
                     $time, result_i.gesture, result_i.press_reported,
                     result_i.report_x, result_i.report_y);
          mismatch_count++;
        end else begin
          want = expected_q.pop_front();
          if (result_i.gesture !== want.gesture ||
              result_i.press_reported !== want.pressed ||
              result_i.report_x !== want.x || result_i.report_y !== want.y) begin
            if (mismatch_count < REPORT_LIMIT)
              $display({"%0t: mismatch: gesture exp %0d got %0d, press exp %0b got %0b, ",
                        "x exp %0d got %0d, y exp %0d got %0d"},
                       $time, want.gesture, result_i.gesture,
                       want.pressed, result_i.press_reported,
                       want.x, result_i.report_x, want.y, result_i.report_y);
            mismatch_count++;
          end else if (want.gesture != GEST_NONE) begin
            swipe_count++;
          end
        end
      end
      if (sample_i.valid && sample_i.ready)
        expected_q.push_back(predict_report(sample_i.pen_down, sample_i.sample_x,
                                            sample_i.sample_y, sample_i.time_ms));
      mismatches_o <= mismatch_count;
      pending_o    <= expected_q.size();
      results_o    <= result_count;
      swipes_o     <= swipe_count;
    end
  end

endmodule

// ===== verif/touch_swipe_gesture_detector_tb.sv =====
`timescale 1ns / 1ps

module touch_swipe_gesture_detector_tb;
  import tsg_pkg::*;

  localparam int unsigned COORD_BITS   = 12;
  localparam int unsigned TIME_BITS    = 32;
  localparam int          COORD_MAX    = (1 << COORD_BITS) - 1;
  localparam int unsigned CLK_PERIOD   = 4;
  localparam int unsigned RESET_CYCLES = 6;
  // Samples per random phase; five phases give roughly two thousand.
  localparam int unsigned PHASE_ITEMS  = 400;
  // Longest sender gap; keeps the idle tail bounded.
  localparam int unsigned MAX_GAP      = 64;
  // Two-stage pipeline: a margin that covers anything still in flight.
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned TAIL_CYCLES   = 8;
  // Cycles with no item moving on either channel before the run is called hung.
  // The longest correct stretch is a capped sender gap or a receiver stall tail
  // at 25 percent ready, both far below this.
  localparam int unsigned STALL_LIMIT   = 2000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  tsg_sample_if #(.COORD_BITS(COORD_BITS), .TIME_BITS(TIME_BITS)) sample_if ();
  tsg_result_if #(.COORD_BITS(COORD_BITS)) result_if ();

  // Flow-control mix of the current phase, in percent
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;

  int unsigned          items_sent = 0;
  int unsigned          idle_cycles = 0;
  logic [TIME_BITS-1:0] now_ms;

  // Thresholds currently loaded, used only to aim the stimulus at the boundaries
  int unsigned cur_min;
  int unsigned cur_dur;
  int unsigned cur_supp;
  int unsigned cur_tap;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned results;
  int unsigned swipes;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  touch_swipe_gesture_detector #(
    .COORD_BITS(COORD_BITS),
    .TIME_BITS (TIME_BITS)
  ) i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .sample_i  (sample_if),
    .result_o  (result_if),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  touch_swipe_gesture_detector_checker #(
    .COORD_BITS(COORD_BITS),
    .TIME_BITS (TIME_BITS)
  ) i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sample_i    (sample_if),
    .result_i    (result_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .mismatches_o(mismatches),
    .pending_o   (pending),
    .results_o   (results),
    .swipes_o    (swipes)
  );

  // Receiver: hold ready low in reset, then drop it on a random share of edges.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: count edges at which no item moves on either channel.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((sample_if.valid && sample_if.ready) ||
                 (result_if.valid && result_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("touch_swipe_gesture_detector verification failed");
    $finish;
  end

  function automatic int on_panel(int v);
    return (v < 0) ? 0 : (v > COORD_MAX) ? COORD_MAX : v;
  endfunction

  // Offer one poll sample and hold it until the block takes it. Valid stays
  // high after acceptance so back-to-back items never toggle it in one step.
  task automatic push_sample(input logic pen, input int unsigned x, input int unsigned y,
                             input logic [TIME_BITS-1:0] stamp);
    int unsigned gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      sample_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    sample_if.valid    <= 1'b1;
    sample_if.pen_down <= pen;
    sample_if.sample_x <= x[COORD_BITS-1:0];
    sample_if.sample_y <= y[COORD_BITS-1:0];
    sample_if.time_ms  <= stamp;
    @(posedge clk_i);
    while (!sample_if.ready) @(posedge clk_i);
    items_sent++;
  endtask

  // Drop valid and wait until every report has come back, then let the
  // pipeline go quiet so thresholds can change.
  task automatic drain();
    sample_if.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write all four thresholds on consecutive edges; write enable stays high
  // across the burst and drops once at the end.
  task automatic load_thresholds(input int unsigned min_d, input int unsigned max_ms,
                                 input int unsigned supp, input int unsigned tap);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_SWIPE_MIN_DIST;
    cfg_data <= min_d[CFG_DATA_W-1:0];
    @(posedge clk_i);
    cfg_idx  <= CFG_SWIPE_MAX_DUR;
    cfg_data <= max_ms[CFG_DATA_W-1:0];
    @(posedge clk_i);
    cfg_idx  <= CFG_SUPPRESS_DIST;
    cfg_data <= supp[CFG_DATA_W-1:0];
    @(posedge clk_i);
    cfg_idx  <= CFG_TAP_CONFIRM;
    cfg_data <= tap[CFG_DATA_W-1:0];
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    cur_min  = min_d;
    cur_dur  = max_ms;
    cur_supp = supp;
    cur_tap  = tap;
  endtask

  // One complete touch: press at the start point, a few moves spread evenly
  // toward the end point, release after dur ms with junk coordinates (they
  // must be ignored), then a pause before the next touch.
  task automatic stroke(input int x0, input int y0, input int x1, input int y1,
                        input int unsigned dur, input int unsigned moves);
    logic [TIME_BITS-1:0] t0;
    t0 = now_ms;
    push_sample(1'b1, x0, y0, t0);
    for (int i = 1; i <= int'(moves); i++)
      push_sample(1'b1, x0 + (x1 - x0) * i / int'(moves), y0 + (y1 - y0) * i / int'(moves),
                  t0 + dur * i / (moves + 1));
    now_ms = t0 + dur;
    push_sample(1'b0, $urandom_range(COORD_MAX), $urandom_range(COORD_MAX), now_ms);
    now_ms += 1 + $urandom_range(cur_tap + 64);
  endtask

  // Swipe aimed at the classifier's edges: dominant travel near the minimum,
  // cross travel near the 3:2 ratio, duration near the limit.
  task automatic random_swipe();
    int major;
    int minor;
    int a0;
    int b0;
    int a1;
    int b1;
    int unsigned dur;
    case ($urandom_range(3))
      0:       major = int'(cur_min) + int'($urandom_range(2)) - 1;
      1:       major = $urandom_range(COORD_MAX);
      default: major = int'(cur_min) + int'($urandom_range(400));
    endcase
    major = on_panel(major);
    case ($urandom_range(3))
      0:       minor = (2 * major) / 3;
      1:       minor = (2 * major - 1) / 3;
      2:       minor = $urandom_range(major);
      default: minor = $urandom_range(major / 4);
    endcase
    minor = on_panel(minor);
    // Place the start so the whole stroke stays on the panel, either direction.
    a0 = $urandom_range(COORD_MAX - major);
    a1 = a0 + major;
    if ($urandom_range(1)) begin
      a0 = a1;
      a1 = a0 - major;
    end
    b0 = $urandom_range(COORD_MAX - minor);
    b1 = b0 + minor;
    if ($urandom_range(1)) begin
      b0 = b1;
      b1 = b0 - minor;
    end
    case ($urandom_range(3))
      0:       dur = cur_dur;
      1:       dur = cur_dur + 1;
      default: dur = $urandom_range(cur_dur);
    endcase
    // Now and then start just short of the timestamp wrap.
    if ($urandom_range(15) == 0) now_ms = '1 - $urandom_range(dur);
    if ($urandom_range(1))
      stroke(a0, b0, a1, b1, dur, $urandom_range(1, 4));
    else
      stroke(b0, a0, b1, a1, dur, $urandom_range(1, 4));
  endtask

  // Short jittery touch held around the tap-confirm window.
  task automatic random_tap();
    int x0;
    int y0;
    x0 = $urandom_range(COORD_MAX);
    y0 = $urandom_range(COORD_MAX);
    stroke(x0, y0,
           on_panel(x0 + int'($urandom_range(2 * cur_supp)) - int'(cur_supp)),
           on_panel(y0 + int'($urandom_range(2 * cur_supp)) - int'(cur_supp)),
           $urandom_range(2 * cur_tap + 20), $urandom_range(1, 5));
  endtask

  // Unstructured polls: random pen, random coordinates, occasional full-range
  // time jumps so every timestamp bit moves.
  task automatic noise_burst();
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(7) == 0)
        now_ms = $urandom();
      else
        now_ms += $urandom_range(50);
      push_sample(1'($urandom_range(1)), $urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
                  now_ms);
    end
  endtask

  task automatic random_phase(input int unsigned idle_pct, input int unsigned stall);
    int unsigned goal;
    goal          = items_sent + PHASE_ITEMS;
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    while (items_sent < goal) begin
      case ($urandom_range(9))
        0:       noise_burst();
        1, 2:    random_tap();
        default: random_swipe();
      endcase
    end
    drain();
  endtask

  initial begin
    // Drive every input to a known value from time zero.
    rst_ni             <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_idx            <= CFG_SWIPE_MIN_DIST;
    cfg_data           <= '0;
    sample_if.valid    <= 1'b0;
    sample_if.pen_down <= 1'b0;
    sample_if.sample_x <= '0;
    sample_if.sample_y <= '0;
    sample_if.time_ms  <= '0;
    now_ms   = 1000;
    cur_min  = RST_SWIPE_MIN_DIST;
    cur_dur  = RST_SWIPE_MAX_DUR;
    cur_supp = RST_SUPPRESS_DIST;
    cur_tap  = RST_TAP_CONFIRM;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, default thresholds, no idling on either side.
    // Release with no press before it: nothing tracked, no gesture.
    push_sample(1'b0, COORD_MAX, COORD_MAX, '1);
    // One clean swipe per direction, two of them starting from opposite panel corners.
    stroke(0, 0, 200, 10, 100, 1);
    stroke(COORD_MAX, COORD_MAX, COORD_MAX - 300, COORD_MAX - 40, 100, 1);
    stroke(500, 100, 510, 300, 150, 1);
    stroke(500, 4000, 500, 3500, 150, 1);
    // Tap held through the confirm window: press shows only after it.
    stroke(1000, 1000, 1004, 1002, 300, 2);
    // Swipe too slow to count.
    stroke(100, 100, 400, 110, 700, 1);
    // Diagonal that misses the 3:2 dominance test.
    stroke(100, 100, 300, 250, 200, 1);
    // Marked as a swipe but short of the minimum travel.
    stroke(3000, 3000, 3050, 3000, 50, 1);
    // Press just before the timestamp wraps, release just after.
    now_ms = 32'hFFFF_FFF0;
    stroke(2000, 2000, 2200, 2000, 32, 1);
    drain();

    // Random phases, each with its own thresholds and flow-control mix.
    random_phase(0, 0);
    // All zero: the press sample itself marks a swipe, only zero duration counts.
    load_thresholds(0, 0, 0, 0);
    random_phase(75, 0);
    // All ones: swipes are all but impossible, presses long held off.
    load_thresholds(COORD_MAX, (1 << CFG_TIME_W) - 1, COORD_MAX, (1 << CFG_TIME_W) - 1);
    random_phase(0, 75);
    load_thresholds($urandom_range(20, 200), $urandom_range(100, 1000),
                    $urandom_range(5, 60), $urandom_range(0, 300));
    random_phase(35, 35);
    load_thresholds($urandom_range(40, 400), $urandom_range(200, 5000),
                    $urandom_range(0, 100), $urandom_range(0, 2000));
    random_phase(0, 0);

    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Summary: %0d poll samples over five threshold settings and four flow mixes",
             items_sent);
    $display("Summary: %0d reports compared, %0d of them classified swipes", results, swipes);
    if (mismatches == 0 && pending == 0) begin
      $display("touch_swipe_gesture_detector verification clean");
    end else begin
      $display("touch_swipe_gesture_detector verification failed");
    end
    $finish;
  end

endmodule
